// ===== rtl/binary_heap_priority_queue_core_assert.svh =====
// Assertion macros of the heap queue RTL, used by the request sequencer.
`ifndef BINARY_HEAP_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_CORE_ASSERT_SVH

// ante implies cons in the same cycle
`define HPQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// ante implies cons in the next cycle
`define HPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// expr never holds
`define HPQ_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error(msg);

`endif

// ===== rtl/hpq_pkg.sv =====
// Types, codes and the entry ordering function of the heap queue.
package hpq_pkg;

	localparam int KEY_W     = 40;
	localparam int ID_W      = 8;
	localparam int CNT_OUT_W = 5;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [ID_W-1:0]  id;
	} entry_t;

	typedef enum logic [1:0] {
		REQ_PUSH   = 2'd0,
		REQ_POP    = 2'd1,
		REQ_REMOVE = 2'd2
	} req_e;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_e;

	typedef struct packed {
		status_e                status;
		entry_t                 popped;
		logic                   top_valid;
		entry_t                 top;
		logic [CNT_OUT_W-1:0]   count;
	} res_t;

	// true when a must sit above b
	function automatic logic entry_precedes(entry_t a, entry_t b, logic tie_mode);
		logic r;
		if (a.key != b.key) begin
			r = (a.key < b.key);
		end else if (tie_mode) begin
			r = (a.id > b.id);
		end else begin
			r = (a.id < b.id);
		end
		return r;
	endfunction

endpackage

// ===== rtl/hpq_if.sv =====
// Request and result channel interfaces of the heap queue.
interface hpq_req_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 req_type;
	logic [hpq_pkg::KEY_W-1:0]  entry_key;
	logic [hpq_pkg::ID_W-1:0]   entry_id;

	modport source (output valid, output req_type, output entry_key, output entry_id,
		input ready);
	modport sink (input valid, input req_type, input entry_key, input entry_id,
		output ready);
endinterface

interface hpq_res_if;
	logic                           valid;
	logic                           ready;
	logic [1:0]                     status;
	logic [hpq_pkg::KEY_W-1:0]      popped_key;
	logic [hpq_pkg::ID_W-1:0]       popped_id;
	logic                           top_valid;
	logic [hpq_pkg::KEY_W-1:0]      top_key;
	logic [hpq_pkg::ID_W-1:0]       top_id;
	logic [hpq_pkg::CNT_OUT_W-1:0]  entry_count;

	modport source (output valid, output status, output popped_key, output popped_id,
		output top_valid, output top_key, output top_id, output entry_count, input ready);
	modport sink (input valid, input status, input popped_key, input popped_id,
		input top_valid, input top_key, input top_id, input entry_count, output ready);
endinterface

// ===== rtl/hpq_mem.sv =====
// Heap entry store: one write port, one registered read port.
module hpq_mem #(
	parameter int DEPTH = 16,
	parameter int IW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IW-1:0]    waddr,
	input  hpq_pkg::entry_t  wdata,
	input  logic             re,
	input  logic [IW-1:0]    raddr,
	output hpq_pkg::entry_t  rdata
);

	hpq_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/hpq_ctrl.sv =====
// Request sequencer: scan, sift up and sift down over the entry store.
`include "binary_heap_priority_queue_core_assert.svh"

module hpq_ctrl #(
	parameter int DEPTH = 16,
	parameter int IW    = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  logic [1:0]                req_type,
	input  logic [hpq_pkg::KEY_W-1:0] entry_key,
	input  logic [hpq_pkg::ID_W-1:0]  entry_id,
	input  logic                      tie_mode,
	output logic                      rslt_valid,
	input  logic                      rslt_ready,
	output hpq_pkg::res_t             rslt,
	output logic                      mem_we,
	output logic [IW-1:0]             mem_waddr,
	output hpq_pkg::entry_t           mem_wdata,
	output logic                      mem_re,
	output logic [IW-1:0]             mem_raddr,
	input  hpq_pkg::entry_t           mem_rdata
);

	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_POP_TOP, S_POP_LAST, S_POP_X, S_SCAN, S_RM_X, S_UP_CHK, S_UP_DATA,
		S_DN_CHK, S_DN_L, S_DN_R, S_DN_DEC, S_TOP_RD, S_DONE
	} state_t;

	typedef enum logic [1:0] {SEL_NONE, SEL_L, SEL_R} sel_t;

	state_t                    state_q;
	logic [CW-1:0]             count_q;
	logic                      is_rm_q;
	logic                      cmp_vld_q;
	logic [IW-1:0]             cmp_idx_q;
	logic [CW-1:0]             scan_ptr_q;
	logic [IW-1:0]             hole_q;
	hpq_pkg::entry_t           x_q;
	hpq_pkg::entry_t           best_q;
	sel_t                      sel_q;
	hpq_pkg::status_e          status_q;
	hpq_pkg::entry_t           popped_q;
	logic [hpq_pkg::ID_W-1:0]  id_q;

	logic [IW+1:0]             l_idx;
	logic [IW+1:0]             r_idx;
	logic [IW+1:0]             cnt_ext;
	logic                      l_in;
	logic                      r_in;
	logic [IW-1:0]             hole_m1;
	logic [IW-1:0]             parent;
	logic [CW-1:0]             last_m1;
	logic                      scan_match;
	logic                      scan_more;
	logic                      up_wins;
	logic                      dn_l_wins;
	logic                      dn_r_wins;
	logic [CW+hpq_pkg::CNT_OUT_W-1:0] cnt_pad;

	assign l_idx      = {1'b0, hole_q, 1'b1};
	assign r_idx      = {1'b0, hole_q, 1'b0} + (IW+2)'(2);
	assign cnt_ext    = (IW+2)'(count_q);
	assign l_in       = (l_idx < cnt_ext);
	assign r_in       = (r_idx < cnt_ext);
	assign hole_m1    = hole_q - IW'(1);
	assign parent     = hole_m1 >> 1;
	assign last_m1    = count_q - CW'(1);
	assign scan_match = cmp_vld_q && (mem_rdata.id == id_q);
	assign scan_more  = (scan_ptr_q < count_q);
	assign up_wins    = hpq_pkg::entry_precedes(x_q, mem_rdata, tie_mode);
	assign dn_l_wins  = hpq_pkg::entry_precedes(mem_rdata, x_q, tie_mode);
	assign dn_r_wins  = hpq_pkg::entry_precedes(mem_rdata, best_q, tie_mode);

	// store access per state
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = hole_q;
		mem_wdata = x_q;
		mem_re    = 1'b0;
		mem_raddr = '0;
		unique case (state_q)
			S_POP_TOP: begin
				mem_re = 1'b1;
			end
			S_POP_LAST: begin
				mem_re    = 1'b1;
				mem_raddr = count_q[IW-1:0];
			end
			S_SCAN: begin
				if (scan_match) begin
					mem_re    = 1'b1;
					mem_raddr = last_m1[IW-1:0];
				end else if (scan_more) begin
					mem_re    = 1'b1;
					mem_raddr = scan_ptr_q[IW-1:0];
				end
			end
			S_UP_CHK: begin
				if (hole_q == '0) begin
					mem_we = !is_rm_q;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = parent;
				end
			end
			S_UP_DATA: begin
				if (up_wins) begin
					mem_we    = 1'b1;
					mem_wdata = mem_rdata;
				end else begin
					mem_we = !is_rm_q;
				end
			end
			S_DN_CHK: begin
				if (l_in) begin
					mem_re    = 1'b1;
					mem_raddr = l_idx[IW-1:0];
				end else begin
					mem_we = 1'b1;
				end
			end
			S_DN_L: begin
				if (r_in) begin
					mem_re    = 1'b1;
					mem_raddr = r_idx[IW-1:0];
				end
			end
			S_DN_DEC: begin
				mem_we    = 1'b1;
				mem_wdata = (sel_q == SEL_NONE) ? x_q : best_q;
			end
			S_TOP_RD: begin
				mem_re = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			is_rm_q   <= 1'b0;
			cmp_vld_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						is_rm_q   <= 1'b0;
						cmp_vld_q <= 1'b0;
						unique case (req_type)
							hpq_pkg::REQ_PUSH: begin
								if (count_q == CW'(DEPTH)) begin
									state_q <= S_TOP_RD;
								end else begin
									count_q <= count_q + CW'(1);
									state_q <= S_UP_CHK;
								end
							end
							hpq_pkg::REQ_POP: begin
								if (count_q == '0) begin
									state_q <= S_TOP_RD;
								end else begin
									count_q <= last_m1;
									state_q <= S_POP_TOP;
								end
							end
							hpq_pkg::REQ_REMOVE: begin
								state_q <= S_SCAN;
							end
							default: begin
								state_q <= S_TOP_RD;
							end
						endcase
					end
				end
				S_POP_TOP: begin
					state_q <= S_POP_LAST;
				end
				S_POP_LAST: begin
					state_q <= S_POP_X;
				end
				S_POP_X: begin
					state_q <= (count_q == '0) ? S_TOP_RD : S_DN_CHK;
				end
				S_SCAN: begin
					if (scan_match) begin
						count_q   <= last_m1;
						is_rm_q   <= 1'b1;
						cmp_vld_q <= 1'b0;
						state_q   <= (CW'(cmp_idx_q) == last_m1) ? S_TOP_RD : S_RM_X;
					end else if (scan_more) begin
						cmp_vld_q <= 1'b1;
					end else begin
						state_q <= S_TOP_RD;
					end
				end
				S_RM_X: begin
					state_q <= S_UP_CHK;
				end
				S_UP_CHK: begin
					if (hole_q == '0) begin
						state_q <= is_rm_q ? S_DN_CHK : S_TOP_RD;
					end else begin
						state_q <= S_UP_DATA;
					end
				end
				S_UP_DATA: begin
					if (up_wins) begin
						state_q <= S_UP_CHK;
					end else begin
						state_q <= is_rm_q ? S_DN_CHK : S_TOP_RD;
					end
				end
				S_DN_CHK: begin
					state_q <= l_in ? S_DN_L : S_TOP_RD;
				end
				S_DN_L: begin
					state_q <= r_in ? S_DN_R : S_DN_DEC;
				end
				S_DN_R: begin
					state_q <= S_DN_DEC;
				end
				S_DN_DEC: begin
					state_q <= (sel_q == SEL_NONE) ? S_TOP_RD : S_DN_CHK;
				end
				S_TOP_RD: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (rslt_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					status_q   <= hpq_pkg::ST_OK;
					popped_q   <= '0;
					id_q       <= entry_id;
					x_q        <= {entry_key, entry_id};
					hole_q     <= count_q[IW-1:0];
					scan_ptr_q <= '0;
					if (req_type == hpq_pkg::REQ_PUSH && count_q == CW'(DEPTH)) begin
						status_q <= hpq_pkg::ST_FULL;
					end
					if (req_type == hpq_pkg::REQ_POP && count_q == '0) begin
						status_q <= hpq_pkg::ST_EMPTY;
					end
				end
			end
			S_POP_LAST: begin
				popped_q <= mem_rdata;
			end
			S_POP_X: begin
				x_q    <= mem_rdata;
				hole_q <= '0;
			end
			S_SCAN: begin
				if (scan_match) begin
					hole_q <= cmp_idx_q;
				end else if (scan_more) begin
					cmp_idx_q  <= scan_ptr_q[IW-1:0];
					scan_ptr_q <= scan_ptr_q + CW'(1);
				end else begin
					status_q <= hpq_pkg::ST_NOT_FOUND;
				end
			end
			S_RM_X: begin
				x_q <= mem_rdata;
			end
			S_UP_DATA: begin
				if (up_wins) begin
					hole_q <= parent;
				end
			end
			S_DN_L: begin
				if (dn_l_wins) begin
					best_q <= mem_rdata;
					sel_q  <= SEL_L;
				end else begin
					best_q <= x_q;
					sel_q  <= SEL_NONE;
				end
			end
			S_DN_R: begin
				if (dn_r_wins) begin
					best_q <= mem_rdata;
					sel_q  <= SEL_R;
				end
			end
			S_DN_DEC: begin
				if (sel_q == SEL_L) begin
					hole_q <= l_idx[IW-1:0];
				end else if (sel_q == SEL_R) begin
					hole_q <= r_idx[IW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// result; the top read of slot zero stays on the read port through S_DONE
	assign cnt_pad          = {{hpq_pkg::CNT_OUT_W{1'b0}}, count_q};
	assign req_ready        = (state_q == S_IDLE);
	assign rslt_valid       = (state_q == S_DONE);
	assign rslt.status      = status_q;
	assign rslt.popped      = popped_q;
	assign rslt.top_valid   = (count_q != '0);
	assign rslt.top         = (count_q != '0) ? mem_rdata : '0;
	assign rslt.count       = cnt_pad[hpq_pkg::CNT_OUT_W-1:0];

	`HPQ_ASSERT_NEVER(a_rw_clash, clk, arst_n, mem_we && mem_re && (mem_waddr == mem_raddr),
		"read and write of the same slot in one cycle")
	`HPQ_ASSERT_NEVER(a_count_range, clk, arst_n, count_q > CW'(DEPTH),
		"entry count above depth")
	`HPQ_ASSERT_IMPL(a_write_in_use, clk, arst_n, mem_we, CW'(mem_waddr) < count_q,
		"write to a slot outside the held entries")
	`HPQ_ASSERT_NEXT(a_push_count, clk, arst_n,
		req_valid && req_ready && (req_type == hpq_pkg::REQ_PUSH) && (count_q != CW'(DEPTH)),
		count_q == $past(count_q) + CW'(1), "push did not advance the count")

endmodule

// ===== rtl/binary_heap_priority_queue_core.sv =====
// Top level of the binary min-heap priority queue.
//
//   channel   dir   handshake        payload
//   req       in    valid / ready    req_type, entry_key, entry_id
//   res       out   valid / ready    status, popped_key/id, top_valid/key/id, entry_count
//   cfg       in    cfg_we           cfg_wdata (tie break mode)
//
// One request at a time over the entry store. A full push, an empty pop and the unused
// code answer without changing the heap. A push sifts up; a pop reads the top and the
// last entry, then sifts down unless it empties the heap. A remove compares slot by
// slot; any slot but the last takes the last entry and sifts up and down. Reset clears
// the entry count and the tie mode, not the store.
// A result waits in the output register; the next request is taken as soon as
// the result has moved there, even while the sink stalls.
module binary_heap_priority_queue_core #(
	parameter int HEAP_DEPTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	hpq_req_if.sink      req,
	hpq_res_if.source    res,
	input  logic         cfg_we,
	input  logic         cfg_wdata
);

	localparam int IW = $clog2(HEAP_DEPTH);

	logic               mode_q;
	logic               out_valid_q;
	hpq_pkg::res_t      out_q;

	logic               rslt_valid;
	logic               rslt_ready;
	hpq_pkg::res_t      rslt;

	logic               mem_we;
	logic [IW-1:0]      mem_waddr;
	hpq_pkg::entry_t    mem_wdata;
	logic               mem_re;
	logic [IW-1:0]      mem_raddr;
	hpq_pkg::entry_t    mem_rdata;

	// tie break mode register; to be written only while idle, which the block does not enforce
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	hpq_ctrl #(
		.DEPTH (HEAP_DEPTH),
		.IW    (IW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_ready  (req.ready),
		.req_type   (req.req_type),
		.entry_key  (req.entry_key),
		.entry_id   (req.entry_id),
		.tie_mode   (mode_q),
		.rslt_valid (rslt_valid),
		.rslt_ready (rslt_ready),
		.rslt       (rslt),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	hpq_mem #(
		.DEPTH (HEAP_DEPTH),
		.IW    (IW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output register: take a finished result whenever the slot is empty or draining
	assign rslt_ready = !out_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rslt_valid && rslt_ready) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the payload while the sink stalls
	always_ff @(posedge clk) begin
		if (rslt_valid && rslt_ready) begin
			out_q <= rslt;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.status      = out_q.status;
	assign res.popped_key  = out_q.popped.key;
	assign res.popped_id   = out_q.popped.id;
	assign res.top_valid   = out_q.top_valid;
	assign res.top_key     = out_q.top.key;
	assign res.top_id      = out_q.top.id;
	assign res.entry_count = out_q.count;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench of the heap queue: directed table, random requests, own heap predictor.
`timescale 1ns / 100ps

module tb_top;

	localparam int HEAP_DEPTH = 16;
	localparam int KEY_W      = hpq_pkg::KEY_W;
	localparam int ID_W       = hpq_pkg::ID_W;
	localparam int CNT_OUT_W  = hpq_pkg::CNT_OUT_W;
	// Longest run of cycles with no request and no result moving before giving up.
	// It covers the receiver hold-off, the slowest request and the longest sender gap.
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_OFF_CYCLES = 300;
	// Request code with no meaning; the block answers it and changes nothing.
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam logic [KEY_W-1:0] KEY_MAX = '1;

	typedef struct {
		logic [1:0]       rt;
		logic [KEY_W-1:0] key;
		logic [ID_W-1:0]  id;
		bit               fixed;
		hpq_pkg::res_t    want;
	} probe_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	hpq_req_if req_ch ();
	hpq_res_if res_ch ();

	binary_heap_priority_queue_core #(
		.HEAP_DEPTH(HEAP_DEPTH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.res      (res_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// Free-running clock, 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Heap predictor: own copy of the store, the count and the tie mode.
	// ------------------------------------------------------------------
	logic [KEY_W-1:0] heap_keys [HEAP_DEPTH];
	logic [ID_W-1:0]  heap_ids  [HEAP_DEPTH];
	int               heap_len;
	logic             tie_mode;

	// Results predicted for accepted requests, oldest first.
	hpq_pkg::res_t pending_results [$];
	probe_t directed_probes [$];

	int  error_count;
	int  send_idle_pct;
	int  recv_stall_pct;
	int  hold_off_left;
	int  quiet_cycles;

	// Typed expectation that rides along with the request being offered.
	bit            offer_fixed;
	hpq_pkg::res_t offer_want;

	// True when slot a belongs above slot b: smaller key, then id by tie mode.
	function automatic bit sits_above(int a, int b);
		if (heap_keys[a] != heap_keys[b])
			return heap_keys[a] < heap_keys[b];
		if (tie_mode)
			return heap_ids[a] > heap_ids[b];
		return heap_ids[a] < heap_ids[b];
	endfunction

	function automatic void swap_slots(int a, int b);
		logic [KEY_W-1:0] k;
		logic [ID_W-1:0]  i;
		k = heap_keys[a];
		i = heap_ids[a];
		heap_keys[a] = heap_keys[b];
		heap_ids[a]  = heap_ids[b];
		heap_keys[b] = k;
		heap_ids[b]  = i;
	endfunction

	function automatic int float_up(int idx);
		int parent;
		while (idx > 0) begin
			parent = (idx - 1) / 2;
			if (!sits_above(idx, parent))
				break;
			swap_slots(idx, parent);
			idx = parent;
		end
		return idx;
	endfunction

	function automatic void sink_down(int idx);
		int  lc;
		int  rc;
		int  best;
		bit  moving;
		moving = 1'b1;
		while (moving) begin
			lc = 2 * idx + 1;
			rc = lc + 1;
			best = idx;
			if (lc < heap_len && sits_above(lc, best))
				best = lc;
			if (rc < heap_len && sits_above(rc, best))
				best = rc;
			if (best == idx) begin
				moving = 1'b0;
			end else begin
				swap_slots(idx, best);
				idx = best;
			end
		end
	endfunction

	// Apply one request to the predicted heap and return the result it yields.
	function automatic hpq_pkg::res_t predict_request(logic [1:0] rt, logic [KEY_W-1:0] k,
		logic [ID_W-1:0] id);
		hpq_pkg::res_t r;
		int            slot;
		r = '0;
		r.status = hpq_pkg::ST_OK;
		case (rt)
			hpq_pkg::REQ_PUSH: begin
				if (heap_len >= HEAP_DEPTH) begin
					r.status = hpq_pkg::ST_FULL;
				end else begin
					heap_keys[heap_len] = k;
					heap_ids[heap_len]  = id;
					heap_len++;
					void'(float_up(heap_len - 1));
				end
			end
			hpq_pkg::REQ_POP: begin
				if (heap_len == 0) begin
					r.status = hpq_pkg::ST_EMPTY;
				end else begin
					r.popped.key = heap_keys[0];
					r.popped.id  = heap_ids[0];
					heap_len--;
					heap_keys[0] = heap_keys[heap_len];
					heap_ids[0]  = heap_ids[heap_len];
					sink_down(0);
				end
			end
			hpq_pkg::REQ_REMOVE: begin
				// first match in array order
				slot = 0;
				while (slot < heap_len && heap_ids[slot] != id)
					slot++;
				if (slot >= heap_len) begin
					r.status = hpq_pkg::ST_NOT_FOUND;
				end else begin
					heap_len--;
					// the last slot just drops; any other takes the last entry and sifts
					if (slot < heap_len) begin
						heap_keys[slot] = heap_keys[heap_len];
						heap_ids[slot]  = heap_ids[heap_len];
						sink_down(float_up(slot));
					end
				end
			end
			default: begin
			end
		endcase
		if (heap_len > 0) begin
			r.top_valid = 1'b1;
			r.top.key   = heap_keys[0];
			r.top.id    = heap_ids[0];
		end
		r.count = 5'(heap_len);
		return r;
	endfunction

	function automatic hpq_pkg::res_t outcome(hpq_pkg::status_e st, logic [KEY_W-1:0] pk,
		logic [ID_W-1:0] pid, logic tv, logic [KEY_W-1:0] tk, logic [ID_W-1:0] tid,
		logic [CNT_OUT_W-1:0] cnt);
		hpq_pkg::res_t r;
		r.status     = st;
		r.popped.key = pk;
		r.popped.id  = pid;
		r.top_valid  = tv;
		r.top.key    = tk;
		r.top.id     = tid;
		r.count      = cnt;
		return r;
	endfunction

	function automatic void add_probe(logic [1:0] rt, logic [KEY_W-1:0] k, logic [ID_W-1:0] id,
		bit fixed, hpq_pkg::res_t want);
		probe_t p;
		p.rt    = rt;
		p.key   = k;
		p.id    = id;
		p.fixed = fixed;
		p.want  = want;
		directed_probes.push_back(p);
	endfunction

	// Key mix: extremes, a narrow band that makes ties common, and full range.
	function automatic logic [KEY_W-1:0] pick_key();
		logic [KEY_W-1:0] k;
		case ($urandom_range(0, 9))
			0: k = '0;
			1: k = KEY_MAX;
			2, 3, 4, 5: k = KEY_W'($urandom_range(0, 7));
			default: begin
				k[KEY_W-1:32] = (KEY_W-32)'($urandom_range(0, 255));
				k[31:0]       = $urandom;
			end
		endcase
		return k;
	endfunction

	// Id mix: a small pool so duplicates show up, plus extremes and full range.
	function automatic logic [ID_W-1:0] pick_id();
		logic [ID_W-1:0] id;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: id = ID_W'($urandom_range(0, 7));
			4: id = '0;
			5: id = '1;
			default: id = ID_W'($urandom_range(0, 255));
		endcase
		return id;
	endfunction

	task automatic report_field(string name, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
		if (want !== got) begin
			error_count++;
			$display("%0t: %s mismatch: expected %h actual %h", $realtime, name, want, got);
		end
	endtask

	// ------------------------------------------------------------------
	// Channel watch: check every result, predict every accepted request.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : watch_channels
		hpq_pkg::res_t got;
		hpq_pkg::res_t want;
		hpq_pkg::res_t predicted;
		if (arst_n) begin
			// Check the result first: it always belongs to an older request.
			if (res_ch.valid && res_ch.ready) begin
				got.status     = hpq_pkg::status_e'(res_ch.status);
				got.popped.key = res_ch.popped_key;
				got.popped.id  = res_ch.popped_id;
				got.top_valid  = res_ch.top_valid;
				got.top.key    = res_ch.top_key;
				got.top.id     = res_ch.top_id;
				got.count      = res_ch.entry_count;
				if (pending_results.size() == 0) begin
					error_count++;
					$display("%0t: result with none expected: expected none actual %h",
						$realtime, got);
				end else begin
					want = pending_results.pop_front();
					report_field("status", KEY_W'(want.status), KEY_W'(got.status));
					report_field("popped_key", want.popped.key, got.popped.key);
					report_field("popped_id", KEY_W'(want.popped.id), KEY_W'(got.popped.id));
					report_field("top_valid", KEY_W'(want.top_valid), KEY_W'(got.top_valid));
					report_field("top_key", want.top.key, got.top.key);
					report_field("top_id", KEY_W'(want.top.id), KEY_W'(got.top.id));
					report_field("entry_count", KEY_W'(want.count), KEY_W'(got.count));
				end
			end
			// Advance the predictor on every accepted request; a typed row overrides it.
			if (req_ch.valid && req_ch.ready) begin
				predicted = predict_request(req_ch.req_type, req_ch.entry_key, req_ch.entry_id);
				pending_results.push_back(offer_fixed ? offer_want : predicted);
			end
		end
	end

	// Watchdog: end the run when nothing moves on either channel for too long.
	always @(posedge clk) begin
		if (arst_n && !(req_ch.valid && req_ch.ready) && !(res_ch.valid && res_ch.ready))
			quiet_cycles++;
		else
			quiet_cycles = 0;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// Receiver: stall at random, or hold off fully while a hold-off is counting down.
	always @(negedge clk) begin
		if (hold_off_left > 0) begin
			hold_off_left <= hold_off_left - 1;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Sender side. Every task starts and ends on a falling edge.
	// ------------------------------------------------------------------
	// Offer one request; idle first at random, then hold valid until accepted.
	task automatic offer_request(logic [1:0] rt, logic [KEY_W-1:0] k, logic [ID_W-1:0] id,
		bit fixed, hpq_pkg::res_t want);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		offer_fixed = fixed;
		offer_want  = want;
		req_ch.valid     <= 1'b1;
		req_ch.req_type  <= rt;
		req_ch.entry_key <= k;
		req_ch.entry_id  <= id;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Drop valid and wait until every predicted result has come out.
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	// Write the tie-break register; the block is idle here, entries may still be held.
	task automatic set_tie_mode(logic v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		tie_mode = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Random requests. Push-heavy in the first half to reach full, pop-heavy after
	// to reach empty; removes mostly name an id that is held.
	task automatic run_random(int n_items);
		int               pick;
		int               push_pct;
		logic [1:0]       rt;
		logic [ID_W-1:0]  id;
		for (int i = 0; i < n_items; i++) begin
			push_pct = (i < n_items / 2) ? 65 : 25;
			pick = $urandom_range(0, 99);
			if (pick < 2)
				rt = REQ_UNUSED;
			else if (pick < 2 + push_pct)
				rt = hpq_pkg::REQ_PUSH;
			else if (pick < 2 + push_pct + (98 - push_pct) / 2)
				rt = hpq_pkg::REQ_POP;
			else
				rt = hpq_pkg::REQ_REMOVE;
			id = pick_id();
			if (rt == hpq_pkg::REQ_REMOVE && heap_len > 0 && $urandom_range(0, 3) != 0)
				id = heap_ids[$urandom_range(0, heap_len - 1)];
			offer_request(rt, pick_key(), id, 1'b0, '0);
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------
	initial begin : main_flow
		int seg_idle  [6];
		int seg_stall [6];
		int seg_mode  [6];
		probe_t p;
		seg_idle  = '{0, 75, 0, 38, 0, 38};
		seg_stall = '{0, 0, 75, 38, 0, 38};
		seg_mode  = '{1, 0, 1, 0, 0, 1};

		// Drive every input to a known value from time zero.
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_wdata        = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.req_type  = hpq_pkg::REQ_PUSH;
		req_ch.entry_key = '0;
		req_ch.entry_id  = '0;
		res_ch.ready     = 1'b0;
		error_count      = 0;
		quiet_cycles     = 0;
		send_idle_pct    = 0;
		recv_stall_pct   = 0;
		hold_off_left    = 0;
		offer_fixed      = 1'b0;
		offer_want       = '0;
		heap_len         = 0;
		tie_mode         = 1'b0;

		// Directed table, tie mode 0 from reset.
		// Empty heap: pop, remove and the unused code all leave it empty.
		add_probe(hpq_pkg::REQ_POP, '0, '0, 1'b1,
			outcome(hpq_pkg::ST_EMPTY, '0, '0, 1'b0, '0, '0, 5'd0));
		add_probe(hpq_pkg::REQ_REMOVE, '0, 8'h5A, 1'b1,
			outcome(hpq_pkg::ST_NOT_FOUND, '0, '0, 1'b0, '0, '0, 5'd0));
		add_probe(REQ_UNUSED, KEY_MAX, 8'hFF, 1'b1,
			outcome(hpq_pkg::ST_OK, '0, '0, 1'b0, '0, '0, 5'd0));
		// Key and id extremes.
		add_probe(hpq_pkg::REQ_PUSH, KEY_MAX, 8'hFF, 1'b1,
			outcome(hpq_pkg::ST_OK, '0, '0, 1'b1, KEY_MAX, 8'hFF, 5'd1));
		add_probe(hpq_pkg::REQ_PUSH, '0, 8'h00, 1'b1,
			outcome(hpq_pkg::ST_OK, '0, '0, 1'b1, '0, 8'h00, 5'd2));
		// Push an entry that stays in the last slot, then remove it: dropped, no sift.
		add_probe(hpq_pkg::REQ_PUSH, KEY_MAX - 1, 8'h33, 1'b0, '0);
		add_probe(hpq_pkg::REQ_REMOVE, '0, 8'h33, 1'b0, '0);
		// Equal keys, tie decided by id.
		add_probe(hpq_pkg::REQ_PUSH, '0, 8'hAA, 1'b0, '0);
		add_probe(hpq_pkg::REQ_PUSH, '0, 8'h55, 1'b0, '0);
		add_probe(hpq_pkg::REQ_PUSH, 40'h80_0000_0000, 8'h01, 1'b0, '0);
		add_probe(REQ_UNUSED, 40'h12_3456_789A, 8'h00, 1'b0, '0);
		// Remove from the middle: the last entry moves in and sifts.
		add_probe(hpq_pkg::REQ_REMOVE, KEY_MAX, 8'hAA, 1'b0, '0);
		add_probe(hpq_pkg::REQ_POP, '0, '0, 1'b0, '0);
		add_probe(hpq_pkg::REQ_REMOVE, '0, 8'h77, 1'b0, '0);
		// Fill to the depth with nonzero keys, duplicates among them.
		add_probe(hpq_pkg::REQ_PUSH, 40'h10, 8'h10, 1'b0, '0);
		add_probe(hpq_pkg::REQ_PUSH, 40'h10, 8'h11, 1'b0, '0);
		add_probe(hpq_pkg::REQ_PUSH, 40'h05, 8'h12, 1'b0, '0);
		add_probe(hpq_pkg::REQ_PUSH, KEY_MAX, 8'h00, 1'b0, '0);
		add_probe(hpq_pkg::REQ_PUSH, 40'h12_3456_789A, 8'h13, 1'b0, '0);
		add_probe(hpq_pkg::REQ_PUSH, 40'h01, 8'hFF, 1'b0, '0);
		add_probe(hpq_pkg::REQ_PUSH, 40'h01, 8'h00, 1'b0, '0);
		add_probe(hpq_pkg::REQ_PUSH, 40'h7F_FFFF_FFFF, 8'h14, 1'b0, '0);
		add_probe(hpq_pkg::REQ_PUSH, 40'h10, 8'h15, 1'b0, '0);
		add_probe(hpq_pkg::REQ_PUSH, 40'h02, 8'h16, 1'b0, '0);
		add_probe(hpq_pkg::REQ_PUSH, 40'hAA_5555_AAAA, 8'h17, 1'b0, '0);
		add_probe(hpq_pkg::REQ_PUSH, 40'h55_AAAA_5555, 8'h18, 1'b0, '0);
		add_probe(hpq_pkg::REQ_PUSH, 40'h03, 8'h19, 1'b0, '0);
		// Full: flagged, nothing changes; the zero-key entry stays on top.
		add_probe(hpq_pkg::REQ_PUSH, '0, 8'h00, 1'b1,
			outcome(hpq_pkg::ST_FULL, '0, '0, 1'b1, '0, 8'h55, CNT_OUT_W'(HEAP_DEPTH)));

		// Hold reset, then release it on a falling edge.
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_probes[i]) begin
			p = directed_probes[i];
			offer_request(p.rt, p.key, p.id, p.fixed, p.want);
		end
		wait_drained();

		// Random part: each segment sets its idling, then the tie mode. Held entries
		// carry over, so a mode change meets a populated heap.
		for (int s = 0; s < 6; s++) begin
			send_idle_pct  = seg_idle[s];
			recv_stall_pct = seg_stall[s];
			set_tie_mode(seg_mode[s][0]);
			// Hold off the receiver while requests keep coming, so the block stalls on a held result.
			if (s == 0)
				hold_off_left <= HOLD_OFF_CYCLES;
			run_random(88);
			wait_drained();
		end

		repeat (40) @(negedge clk);
		if (error_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
